// ===== rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps

package ctl_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int SLOT_W = 4;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic [7:0]  protocol;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic        is_ipv6;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } entry_type;

endpackage

// ===== rtl/ctl_entry_mem.sv =====
`timescale 1ns / 1ps

module ctl_entry_mem
   import ctl_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int PW = $clog2(NUM_SLOTS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [PW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [PW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type entry_mem_ff [NUM_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ctl_slot_cmp.sv =====
`timescale 1ns / 1ps

module ctl_slot_cmp
   import ctl_pkg::*;
(
   input  entry_type query,
   input  entry_type entry,
   output logic      match
);

   logic proto_ok;
   logic lport_ok;
   logic rport_ok;
   logic addr_eq;
   logic addr_zero;

   always_comb begin
      proto_ok = (query.protocol == entry.protocol);
      lport_ok = (query.local_port == 16'd0) || (query.local_port == entry.local_port);
      rport_ok = (query.remote_port == 16'd0) || (query.remote_port == entry.remote_port);
      if (entry.is_ipv6) begin
         addr_eq   = (entry.addr_hi == query.addr_hi) && (entry.addr_lo == query.addr_lo);
         addr_zero = (entry.addr_hi == 64'd0) && (entry.addr_lo == 64'd0);
      end else begin
         addr_eq   = (entry.addr_lo[31:0] == query.addr_lo[31:0]);
         addr_zero = (entry.addr_lo[31:0] == 32'd0);
      end
      match = proto_ok && lport_ok && rport_ok && (addr_eq || addr_zero);
   end

endmodule

// ===== rtl/connection_table_lookup.sv =====
`timescale 1ns / 1ps
// Lookup: one slot is compared per cycle through the entry memory read port, so the first
// active matching slot in index order is reported as a hit, and a miss once every slot is read.
// Add: the slots are checked in order and the first free one takes the entry; a full table fails.
// Delete and unknown actions report in the cycle after start. busy is high while a scan runs,
// and no start is taken while busy; a new one can be given while rsp_valid is high.
// Reset empties the table at once; the receiver cannot stall, and rsp_valid lasts one cycle.
module connection_table_lookup
   import ctl_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_slot_index,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_local_port,
   input  logic [15:0] req_remote_port,
   input  logic        req_is_ipv6,
   input  logic [63:0] req_remote_addr_hi,
   input  logic [63:0] req_remote_addr_lo,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [3:0]  rsp_result_slot,
   output logic        rsp_bad_index
);

   localparam int PW = $clog2(NUM_SLOTS);
   localparam logic [PW-1:0] LAST_SLOT = PW'(NUM_SLOTS - 1);

   state_type            state_ff, state_in;
   logic [PW-1:0]        ptr_ff, ptr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [PW-1:0]        rd_slot_ff, rd_slot_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   entry_type            query_ff, query_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_success_ff, rsp_success_in;
   logic [SLOT_W-1:0]    rsp_result_slot_ff, rsp_result_slot_in;
   logic                 rsp_bad_index_ff, rsp_bad_index_in;

   logic                 mem_wr_en;
   entry_type            mem_rd_data;
   logic                 slot_match;

   ctl_entry_mem #(
      .NUM_SLOTS (NUM_SLOTS),
      .PW        (PW)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (query_ff),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd_data)
   );

   ctl_slot_cmp u_slot_cmp (
      .query (query_ff),
      .entry (mem_rd_data),
      .match (slot_match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff             <= ptr_in;
      rd_slot_ff         <= rd_slot_in;
      query_ff           <= query_in;
      rsp_success_ff     <= rsp_success_in;
      rsp_result_slot_ff <= rsp_result_slot_in;
      rsp_bad_index_ff   <= rsp_bad_index_in;
   end

   always_comb begin
      state_in           = state_ff;
      ptr_in             = ptr_ff;
      rd_valid_in        = 1'b0;
      rd_slot_in         = rd_slot_ff;
      active_in          = active_ff;
      query_in           = query_ff;
      rsp_valid_in       = 1'b0;
      rsp_success_in     = 1'b0;
      rsp_result_slot_in = '0;
      rsp_bad_index_in   = 1'b0;
      mem_wr_en          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               query_in.protocol    = req_protocol;
               query_in.local_port  = req_local_port;
               query_in.remote_port = req_remote_port;
               query_in.is_ipv6     = req_is_ipv6;
               query_in.addr_hi     = req_remote_addr_hi;
               query_in.addr_lo     = req_remote_addr_lo;
               ptr_in               = '0;
               case (req_action)
                  ACT_LOOKUP: begin
                     state_in = ST_LOOK;
                  end
                  ACT_ADD: begin
                     state_in = ST_ADD;
                  end
                  ACT_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_slot_index) < NUM_SLOTS) begin
                        active_in[PW'(32'(req_slot_index))] = 1'b0;
                        rsp_success_in = 1'b1;
                     end else begin
                        rsp_bad_index_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (!active_ff[ptr_ff]) begin
               mem_wr_en          = 1'b1;
               active_in[ptr_ff]  = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_success_in     = 1'b1;
               rsp_result_slot_in = SLOT_W'(32'(ptr_ff));
               state_in           = ST_IDLE;
            end else if (ptr_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
         ST_LOOK: begin
            if (rd_valid_ff && active_ff[rd_slot_ff] && slot_match) begin
               rsp_valid_in       = 1'b1;
               rsp_success_in     = 1'b1;
               rsp_result_slot_in = SLOT_W'(32'(rd_slot_ff));
               state_in           = ST_IDLE;
            end else if (rd_valid_ff && (rd_slot_ff == LAST_SLOT)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_valid_in = 1'b1;
               rd_slot_in  = ptr_ff;
               ptr_in      = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + PW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_result_slot = rsp_result_slot_ff;
   assign rsp_bad_index   = rsp_bad_index_ff;

endmodule
